// ----- src/vel_pkg.sv -----
// ----------------------------------------------------------------------------
// vel_pkg
// Shared types and constants of the vector length unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vel_pkg;

  localparam int MAX_VECTOR_LEN = 16;

  localparam int ELEM_W = 16;
  localparam int EPS_W  = 16;
  localparam int LEN_W  = 18;
  localparam int MAG_W  = 16;
  localparam int SQ_W   = 31;

  localparam int SUM_W      = $clog2(MAX_VECTOR_LEN) + SQ_W;
  localparam int ROOT_STEPS = (SUM_W + 1) / 2;
  localparam int RAD_W      = 2 * ROOT_STEPS;
  localparam int REM_W      = ROOT_STEPS + 2;
  localparam int CNT_W      = $clog2(ROOT_STEPS + 1);

  localparam logic [SUM_W-1:0] SUM_CAP = SUM_W'(longint'(MAX_VECTOR_LEN) << 30);
  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(107);

  // power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [SUM_W-1:0] radicand;
    logic             saturated;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ----- src/vel_in_if.sv -----
// ----------------------------------------------------------------------------
// vel_in_if
// Element channel: one vector component per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface vel_in_if import vel_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] element;
  logic                     last_element;

  modport source (output valid, output element, output last_element, input ready);
  modport sink   (input valid, input element, input last_element, output ready);
endinterface

`default_nettype wire

// ----- src/vel_out_if.sv -----
// ----------------------------------------------------------------------------
// vel_out_if
// Length channel: one vector length per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface vel_out_if import vel_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] length;
  logic             saturated;

  modport source (output valid, output length, output saturated, input ready);
  modport sink   (input valid, input length, input saturated, output ready);
endinterface

`default_nettype wire

// ----- src/vector_euclidean_length_unit.sv -----
// ----------------------------------------------------------------------------
// vector_euclidean_length_unit
// Euclidean length of streamed vectors, Q1.15 in, unsigned Q.15 out.
// ----------------------------------------------------------------------------
// Throughput: one element per cycle, but the last element of a vector waits
//   while the queue is full. The back end works on one root at a time, one
//   bit a cycle, and takes the next sum only once its result is registered.
// The two-entry queue lets accumulation run on while a root is in progress.
// Reset clears the sum, the saturation flag and the queue, epsilon reads 107.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_euclidean_length_unit import vel_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  vel_in_if.sink                elements,
  vel_out_if.source             lengths,
  input  wire logic             cfg_we,
  input  wire logic [EPS_W-1:0] cfg_wdata
);

  logic    push;
  logic    pop;
  entry_t  push_entry;
  entry_t  head;
  q_stat_t qstat;

  vel_front u_front (
    .clk       (clk),
    .rst       (rst),
    .elements  (elements),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .qstat     (qstat),
    .push      (push),
    .entry     (push_entry)
  );

  vel_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  vel_back u_back (
    .clk     (clk),
    .rst     (rst),
    .qstat   (qstat),
    .head    (head),
    .pop     (pop),
    .lengths (lengths)
  );

endmodule

`default_nettype wire

// ----- src/vel_front.sv -----
// ----------------------------------------------------------------------------
// vel_front
// Squares each element and keeps the saturating sum of squares; on the last
// element of a vector it queues the biased sum for the root.
// ----------------------------------------------------------------------------
`default_nettype none

module vel_front import vel_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  vel_in_if.sink                elements,
  input  wire logic             cfg_we,
  input  wire logic [EPS_W-1:0] cfg_wdata,
  input  wire q_stat_t          qstat,
  output logic                  push,
  output entry_t                entry
);

  logic [EPS_W-1:0] epsilon;
  logic             s1_valid;
  logic             s1_last;
  logic [SQ_W-1:0]  s1_sq;
  logic [SUM_W-1:0] square_sum;
  logic             overflow_seen;

  logic [MAG_W-1:0] mag;
  logic [2*MAG_W-1:0] sq_full;
  logic             s1_go;
  logic [SUM_W:0]   total;
  logic             sat_now;
  logic [SUM_W-1:0] sum_next;
  logic             overflow_next;

  always_comb begin
    mag     = elements.element[ELEM_W-1] ? MAG_W'(~elements.element + 1'b1)
                                         : MAG_W'(elements.element);
    sq_full = mag * mag;
    s1_go   = s1_valid && (!s1_last || !qstat.full);
    total   = {1'b0, square_sum} + {{(SUM_W+1-SQ_W){1'b0}}, s1_sq};
    sat_now = (total > {1'b0, SUM_CAP});
    sum_next      = sat_now ? SUM_CAP : total[SUM_W-1:0];
    overflow_next = overflow_seen | sat_now;
  end

  assign elements.ready = !s1_valid || s1_go;
  assign push           = s1_go && s1_last;
  assign entry.radicand = sum_next + {{(SUM_W-EPS_W){1'b0}}, epsilon};
  assign entry.saturated = overflow_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon       <= EPS_RESET;
      s1_valid      <= 1'b0;
      square_sum    <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cfg_we) begin
        epsilon <= cfg_wdata;
      end
      if (elements.valid && elements.ready) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        if (s1_last) begin
          square_sum    <= '0;
          overflow_seen <= 1'b0;
        end else begin
          square_sum    <= sum_next;
          overflow_seen <= overflow_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (elements.valid && elements.ready) begin
      s1_sq   <= sq_full[SQ_W-1:0];
      s1_last <= elements.last_element;
    end
  end

endmodule

`default_nettype wire

// ----- src/vel_queue.sv -----
// ----------------------------------------------------------------------------
// vel_queue
// Short queue of biased sums between accumulation and root.
// ----------------------------------------------------------------------------
`default_nettype none

module vel_queue import vel_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output entry_t      head,
  output q_stat_t     qstat
);

  entry_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign head        = entries[rd_ptr];
  assign qstat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> !push)
    else $error("item pushed into full queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    qstat.empty |-> !pop)
    else $error("item popped from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count missed a push");

endmodule

`default_nettype wire

// ----- src/vel_back.sv -----
// ----------------------------------------------------------------------------
// vel_back
// Digit-by-digit integer square root, two radicand bits a cycle, with an
// output register towards the length channel.
// ----------------------------------------------------------------------------
`default_nettype none

module vel_back import vel_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire q_stat_t qstat,
  input  wire entry_t  head,
  output logic         pop,
  vel_out_if.source    lengths
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;
  localparam int   EXT_W   = ROOT_STEPS + LEN_W;
  localparam logic [EXT_W-1:0] LEN_MAX = EXT_W'({LEN_W{1'b1}});

  logic                  state;
  logic [CNT_W-1:0]      cnt;
  logic [RAD_W-1:0]      rad;
  logic [REM_W-1:0]      rem;
  logic [ROOT_STEPS-1:0] root;
  logic                  sat;
  logic                  o_valid;
  logic [LEN_W-1:0]      o_length;
  logic                  o_sat;

  logic [REM_W-1:0]      rem_sh;
  logic [REM_W-1:0]      trial;
  logic                  ge;
  logic [EXT_W-1:0]      root_ext;
  logic [LEN_W-1:0]      len_clamped;
  logic                  finish;

  always_comb begin
    rem_sh      = {rem[REM_W-3:0], rad[RAD_W-1:RAD_W-2]};
    trial       = {root, 2'b01};
    ge          = (rem_sh >= trial);
    root_ext    = EXT_W'(root);
    len_clamped = (root_ext > LEN_MAX) ? {LEN_W{1'b1}} : root_ext[LEN_W-1:0];
    finish      = (state == ST_RUN) && (cnt == '0) && (!o_valid || lengths.ready);
    pop         = (state == ST_IDLE) && !qstat.empty;
  end

  assign lengths.valid     = o_valid;
  assign lengths.length    = o_length;
  assign lengths.saturated = o_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      o_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            state <= ST_RUN;
            cnt   <= CNT_W'(ROOT_STEPS);
          end
        end
        ST_RUN: begin
          if (cnt != '0) begin
            cnt <= cnt - 1'b1;
          end else if (finish) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (finish) begin
        o_valid <= 1'b1;
      end else if (lengths.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rad  <= RAD_W'(head.radicand);
      rem  <= '0;
      root <= '0;
      sat  <= head.saturated;
    end else if ((state == ST_RUN) && (cnt != '0)) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= ge ? (rem_sh - trial) : rem_sh;
      root <= {root[ROOT_STEPS-2:0], ge};
    end
    if (finish) begin
      o_length <= len_clamped;
      o_sat    <= sat;
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == ST_RUN) && (cnt == CNT_W'(ROOT_STEPS)))
    else $error("root did not start after pop");

  a_finish_done: assert property (@(posedge clk) disable iff (rst)
    finish |-> (cnt == '0) && (state == ST_RUN))
    else $error("result taken before root finished");

  a_finish_fills: assert property (@(posedge clk) disable iff (rst)
    finish |=> o_valid)
    else $error("finished root not presented");

endmodule

`default_nettype wire
